@@ rtl/lfpe_pkg.sv @@
// shared types and constants of the linear factor product expander
package lfpe_pkg;

  localparam int MAX_ORDER_DEF = 32;

  localparam logic [31:0] PERIOD_RST = 32'd89478;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_TWO   = 64'h0000_0002_0000_0000;
  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_ADEN = 2'd0,
    MODE_DNUM = 2'd1,
    MODE_DDEN = 2'd2,
    MODE_ANUM = 2'd3
  } mode_t;

  typedef struct packed {
    logic [63:0] c0r;
    logic [63:0] c0i;
    logic [63:0] c1r;
    logic [63:0] c1i;
    logic        single;
    logic        last;
  } fact_t;

endpackage

@@ rtl/lfpe_front.sv @@
// front end: accepts poles and forms the first-order factor coefficients
module lfpe_front import lfpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pole_real,
  input  logic [31:0] in_pole_imag,
  input  logic        in_last_pole,
  input  mode_t       mode,
  input  logic [31:0] period,
  input  logic        q_full,
  output logic        q_push,
  output fact_t       q_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state_r;
  logic [31:0] pr_r, pi_r, per_r;
  logic        last_r;
  mode_t       mode_r;
  logic [63:0] xr_r, xi_r;
  logic [31:0] mag_re, mag_im;
  logic [63:0] tr, ti, p_re, p_im;

  assign busy = (state_r != F_IDLE);

  assign mag_re = pr_r[31] ? (32'd0 - pr_r) : pr_r;
  assign mag_im = pi_r[31] ? (32'd0 - pi_r) : pi_r;

  // pole part times period, floored, with the wrap of the 64-bit form
  function automatic logic [63:0] tp(input logic sgn, input logic [63:0] x);
    logic [63:0] x48;
    x48 = {16'd0, x[47:0]};
    if (!sgn) return x48;
    if (x48 == 64'd0) return 64'hFFFF_0000_0000_0000;
    return 64'd0 - x48;
  endfunction

  assign tr   = tp(pr_r[31], xr_r);
  assign ti   = tp(pi_r[31], xi_r);
  assign p_re = {{16{pr_r[31]}}, pr_r, 16'd0};
  assign p_im = {{16{pi_r[31]}}, pi_r, 16'd0};

  always_comb begin
    q_data.single = 1'b0;
    q_data.last   = last_r;
    case (mode_r)
      MODE_ADEN: begin
        q_data.c0r = 64'd0 - p_re;
        q_data.c0i = 64'd0 - p_im;
        q_data.c1r = Q_ONE;
        q_data.c1i = 64'd0;
      end
      MODE_DNUM: begin
        q_data.c0r = tr;
        q_data.c0i = ti;
        q_data.c1r = tr;
        q_data.c1i = ti;
      end
      MODE_DDEN: begin
        q_data.c0r = 64'd0 - Q_TWO - tr;
        q_data.c0i = 64'd0 - ti;
        q_data.c1r = Q_TWO - tr;
        q_data.c1i = 64'd0 - ti;
      end
      default: begin
        q_data.c0r    = p_re;
        q_data.c0i    = p_im;
        q_data.c1r    = 64'd0;
        q_data.c1i    = 64'd0;
        q_data.single = 1'b1;
      end
    endcase
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: if (start) state_r <= F_MUL;
        F_MUL:  state_r <= F_PUSH;
        F_PUSH: if (!q_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      pr_r   <= in_pole_real;
      pi_r   <= in_pole_imag;
      last_r <= in_last_pole;
      mode_r <= mode;
      per_r  <= period;
    end
    if (state_r == F_MUL) begin
      xr_r <= 64'(mag_re) * 64'(per_r);
      xi_r <= 64'(mag_im) * 64'(per_r);
    end
  end

endmodule

@@ rtl/lfpe_queue.sv @@
// two-entry factor queue between front and back end
module lfpe_queue import lfpe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  fact_t din,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output fact_t dout
);

  fact_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= din;
  end

endmodule

@@ rtl/lfpe_back.sv @@
// back end: coefficient store, multiply-accumulate sequencer and word output
module lfpe_back import lfpe_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  fact_t       q_data,
  output logic        q_pop,
  output logic        out_strobe,
  output logic [5:0]  out_coef_index,
  output logic [63:0] out_coef_real,
  output logic [63:0] out_coef_imag,
  output logic        out_last_coef,
  output logic        out_saturated,
  output logic        out_too_many_poles
);

  localparam int DEPTH = MAX_ORDER + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RDA  = 10'b00_0000_0010,
    S_RDB  = 10'b00_0000_0100,
    S_LATB = 10'b00_0000_1000,
    S_MUL  = 10'b00_0001_0000,
    S_DRN  = 10'b00_0010_0000,
    S_RND  = 10'b00_0100_0000,
    S_CHK  = 10'b00_1000_0000,
    S_EM   = 10'b01_0000_0000,
    S_CLR  = 10'b10_0000_0000
  } bstate_t;

  bstate_t         state_r;
  logic [127:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [127:0]    rd_data_r;
  logic            rd_vld_r, rd_z_r;
  logic [AW-1:0]   rd_addr;
  logic [63:0]     rv_re, rv_im;

  logic [63:0]     c0r_r, c0i_r, c1r_r, c1i_r;
  logic            single_r, last_r;
  logic [AW-1:0]   k_r, e_r, top_r, pc_r;
  logic            sat_r, ovf_r;
  logic [127:0]    a_r, b_r;
  logic [3:0]      cnt_r;
  logic            ph_r;
  logic signed [127:0] acc_r;
  logic [63:0]     pp_r;
  logic [1:0]      sh_r;
  logic            ng_r, ppv_r;
  logic [63:0]     res_re_r;
  logic            pend_r, pend_last_r;
  logic [AW-1:0]   pend_idx_r;

  logic [63:0]     a_op, b_op, amag, bmag;
  logic            tneg;
  logic [2:0]      term;
  logic [31:0]     a_half, b_half;
  logic [127:0]    ext, rsum;
  logic            r_ovf;
  logic [63:0]     r_val;

  always_comb begin
    case (state_r)
      S_RDB:   rd_addr = (k_r == '0) ? '0 : k_r - AW'(1);
      S_EM:    rd_addr = e_r;
      default: rd_addr = k_r;
    endcase
  end

  assign rv_re = rd_vld_r ? rd_data_r[127:64] : (rd_z_r ? Q_ONE : 64'd0);
  assign rv_im = rd_vld_r ? rd_data_r[63:0] : 64'd0;

  assign term = {ph_r, cnt_r[3:2]};

  always_comb begin
    case (term)
      3'd0: begin a_op = c0r_r; b_op = a_r[127:64]; tneg = 1'b0; end
      3'd1: begin a_op = c0i_r; b_op = a_r[63:0];   tneg = 1'b1; end
      3'd2: begin a_op = c1r_r; b_op = b_r[127:64]; tneg = 1'b0; end
      3'd3: begin a_op = c1i_r; b_op = b_r[63:0];   tneg = 1'b1; end
      3'd4: begin a_op = c0r_r; b_op = a_r[63:0];   tneg = 1'b0; end
      3'd5: begin a_op = c0i_r; b_op = a_r[127:64]; tneg = 1'b0; end
      3'd6: begin a_op = c1r_r; b_op = b_r[63:0];   tneg = 1'b0; end
      default: begin a_op = c1i_r; b_op = b_r[127:64]; tneg = 1'b0; end
    endcase
  end

  assign amag   = a_op[63] ? (64'd0 - a_op) : a_op;
  assign bmag   = b_op[63] ? (64'd0 - b_op) : b_op;
  assign a_half = cnt_r[1] ? amag[63:32] : amag[31:0];
  assign b_half = cnt_r[0] ? bmag[63:32] : bmag[31:0];

  always_comb begin
    case (sh_r)
      2'd0:    ext = {64'd0, pp_r};
      2'd1:    ext = {32'd0, pp_r, 32'd0};
      default: ext = {pp_r, 64'd0};
    endcase
  end

  assign rsum  = acc_r + 128'h8000_0000;
  assign r_ovf = !((rsum[127:95] == '0) || (rsum[127:95] == '1));
  assign r_val = r_ovf ? (rsum[127] ? SAT_NEG : SAT_POS) : rsum[95:32];

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  assign out_strobe         = pend_r;
  assign out_coef_index     = 6'(pend_idx_r);
  assign out_coef_real      = rv_re;
  assign out_coef_imag      = rv_im;
  assign out_last_coef      = pend_last_r;
  assign out_saturated      = sat_r;
  assign out_too_many_poles = ovf_r;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
    rd_z_r    <= (rd_addr == '0);
    if (state_r == S_RND && ph_r) mem[k_r] <= {res_re_r, r_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      pc_r    <= '0;
      sat_r   <= 1'b0;
      ovf_r   <= 1'b0;
      ppv_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      ppv_r  <= 1'b0;
      pend_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            c0r_r    <= q_data.c0r;
            c0i_r    <= q_data.c0i;
            c1r_r    <= q_data.c1r;
            c1i_r    <= q_data.c1i;
            single_r <= q_data.single;
            last_r   <= q_data.last;
            if (pc_r >= AW'(MAX_ORDER)) begin
              ovf_r   <= 1'b1;
              state_r <= S_CHK;
            end else begin
              k_r     <= q_data.single ? '0 : pc_r + AW'(1);
              state_r <= S_RDA;
            end
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r     <= {rv_re, rv_im};
          state_r <= S_LATB;
        end
        S_LATB: begin
          b_r     <= (k_r == '0) ? 128'd0 : {rv_re, rv_im};
          cnt_r   <= 4'd0;
          ph_r    <= 1'b0;
          acc_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          pp_r  <= 64'(a_half) * 64'(b_half);
          sh_r  <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
          ng_r  <= a_op[63] ^ b_op[63] ^ tneg;
          ppv_r <= 1'b1;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= S_DRN;
        end
        S_DRN: state_r <= S_RND;
        S_RND: begin
          if (r_ovf) sat_r <= 1'b1;
          if (!ph_r) begin
            res_re_r <= r_val;
            ph_r     <= 1'b1;
            acc_r    <= '0;
            cnt_r    <= 4'd0;
            state_r  <= S_MUL;
          end else begin
            valid_r[k_r] <= 1'b1;
            if (k_r == '0) begin
              pc_r    <= pc_r + AW'(1);
              state_r <= S_CHK;
            end else begin
              k_r     <= k_r - AW'(1);
              state_r <= S_RDA;
            end
          end
        end
        S_CHK: begin
          if (last_r) begin
            e_r     <= '0;
            top_r   <= single_r ? '0 : pc_r;
            state_r <= S_EM;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EM: begin
          pend_r      <= 1'b1;
          pend_idx_r  <= e_r;
          pend_last_r <= (e_r == top_r);
          if (e_r == top_r) state_r <= S_CLR;
          else e_r <= e_r + AW'(1);
        end
        S_CLR: begin
          valid_r <= '0;
          pc_r    <= '0;
          sat_r   <= 1'b0;
          ovf_r   <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (ppv_r) acc_r <= ng_r ? acc_r - $signed(ext) : acc_r + $signed(ext);
    end
  end

endmodule

@@ rtl/linear_factor_product_expander.sv @@
// top level of the linear factor product expander
//
// channel  direction  handshake                 payload
// in_      input      start high, busy low      in_pole_real, in_pole_imag, in_last_pole
// out_     output     out_strobe, one cycle     index, real, imag, last, saturated, too many
// cfg_     input      cfg_we                    cfg_index, cfg_wdata
//
// a pole updates pole count + 2 stored coefficients, one in the product mode, each formed
// with the single 32x32 multiplier of the back end
// emission of n coefficients gives one word per cycle
// the front end takes a new pole only while idle, once the previous one is pushed to the queue
// synchronous reset returns the store to the constant one at once
module linear_factor_product_expander import lfpe_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pole_real,
  input  logic [31:0] in_pole_imag,
  input  logic        in_last_pole,
  output logic        out_strobe,
  output logic [5:0]  out_coef_index,
  output logic [63:0] out_coef_real,
  output logic [63:0] out_coef_imag,
  output logic        out_last_coef,
  output logic        out_saturated,
  output logic        out_too_many_poles,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  mode_t       mode_r;
  logic [31:0] period_r;
  logic        q_full, q_push, q_empty, q_pop;
  fact_t       q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ADEN;
      period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= mode_t'(cfg_wdata[1:0]);
        CFG_PERIOD: period_r <= cfg_wdata;
        default:    period_r <= period_r;
      endcase
    end
  end

  lfpe_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_pole_real, .in_pole_imag, .in_last_pole,
    .mode(mode_r), .period(period_r),
    .q_full, .q_push, .q_data(q_din)
  );

  lfpe_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_dout)
  );

  lfpe_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_dout), .q_pop,
    .out_strobe, .out_coef_index, .out_coef_real, .out_coef_imag,
    .out_last_coef, .out_saturated, .out_too_many_poles
  );

endmodule

@@ rtl/lfpe_checker.sv @@
// port-level checks of the expander output sequence and their binding
module lfpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_strobe,
  input logic [5:0] out_coef_index,
  input logic       out_last_coef
);

  // words of one run come back to back
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_coef |=> out_strobe)
    else $error("gap inside a coefficient run");

  a_incr: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_coef |=> out_coef_index == $past(out_coef_index) + 6'd1)
    else $error("coefficient index not increasing");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> out_coef_index == 6'd0)
    else $error("run does not start at index zero");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_coef |=> !out_strobe)
    else $error("word right after the last coefficient");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("word after reset");

endmodule

bind linear_factor_product_expander lfpe_checker u_chk (
  .clk, .rst_n, .out_strobe, .out_coef_index, .out_last_coef
);
